[rtl/lbfl_pkg.sv]
// Shared widths, opcodes and status codes of the linked block free-list allocator.
package lbfl_pkg;

  localparam int OPCODE_W = 3;
  localparam int FIELD_W  = 9;
  localparam int OFFSET_W = 24;
  localparam int STATUS_W = 2;
  localparam int STRIDE_W = 16;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd64;

  localparam logic [OPCODE_W-1:0] OP_ALLOC      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC_LINK = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE       = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_FREE_CHAIN = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_GET_LINK   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_SET_LINK   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd2;

endpackage

[rtl/lbfl_ram.sv]
// Simple dual-port synchronous RAM with one write port and one registered read port.
module lbfl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/linked_block_free_list_allocator.sv]
// Top level of the linked block free-list allocator: free stack, chain links and control.
//
// This block manages a pool of BLOCK_COUNT equal blocks. Free blocks form a stack linked
// by index, kept in one RAM (the free links) with the head in a register; a second RAM
// holds one chain link per block so that blocks can be strung into chains. Each accepted
// beat carries an opcode: allocate, allocate and append to a given block, free one block
// (returning its chain successor), free a whole chain, read a link or set a link. Every
// input beat yields exactly one result beat with the block index, its byte offset
// (index times block_stride, modulo 2^24, zero when there is no block) and a status.
// After reset the block runs a clearing pass over every block that loads the free
// links; input ready stays low during it, while block_stride writes are taken at any time.
// Alloc, free, get link and set link each first read the RAMs, then modify and write
// back. A successful alloc and link with an in-range given block adds a link step,
// since its second chain-link write needs the single RAM write port again.
// Free chain walks the chain with one chain-link read per block.
// The result sits in an output register, so the next beat is taken while it waits.
// Chain links of blocks that were never allocated or set read back as arbitrary values.
module linked_block_free_list_allocator #(
  parameter int BLOCK_COUNT = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic        [lbfl_pkg::STRIDE_W-1:0]   cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [lbfl_pkg::OPCODE_W-1:0]   opcode,
  input  logic signed [lbfl_pkg::FIELD_W-1:0]    block,
  input  logic signed [lbfl_pkg::FIELD_W-1:0]    link_target,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lbfl_pkg::FIELD_W-1:0]    result_block,
  output logic        [lbfl_pkg::OFFSET_W-1:0]   byte_offset,
  output logic        [lbfl_pkg::STATUS_W-1:0]   status
);

  import lbfl_pkg::*;

  // IW indexes the pool; LW holds an index plus the two negative markers.
  // Chain links are at least as wide as the input field so set link stores it unchanged.
  localparam int IW = $clog2(BLOCK_COUNT);
  localparam int LW = IW + 1;
  localparam int CW = (LW > FIELD_W) ? LW : FIELD_W;
  localparam int PW = CW + STRIDE_W;

  localparam logic signed [LW-1:0] TAKEN_L = LW'(-2);
  localparam logic signed [CW-1:0] NONE_C  = CW'(-1);
  localparam logic [IW-1:0]        LAST_IDX = IW'(BLOCK_COUNT - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;

  function automatic logic in_pool(input logic signed [CW-1:0] v);
    return !v[CW-1] && (32'({1'b0, v[CW-2:0]}) < BLOCK_COUNT);
  endfunction

  logic [2:0]               state;
  logic [IW-1:0]            clr_cnt;
  logic signed [LW-1:0]     head;
  logic [STRIDE_W-1:0]      block_stride;
  logic                     pend;

  logic [OPCODE_W-1:0]      op_r;
  logic signed [CW-1:0]     blk_r;
  logic signed [CW-1:0]     tgt_r;
  logic signed [CW-1:0]     res;
  logic [STATUS_W-1:0]      st;
  logic signed [CW-1:0]     cur;
  logic [IW:0]              walk_n;

  logic                     fl_we;
  logic [IW-1:0]            fl_waddr;
  logic [LW-1:0]            fl_wdata;
  logic [IW-1:0]            fl_raddr;
  logic [LW-1:0]            fl_rdata;
  logic                     cl_we;
  logic [IW-1:0]            cl_waddr;
  logic [CW-1:0]            cl_wdata;
  logic [IW-1:0]            cl_raddr;
  logic [CW-1:0]            cl_rdata;

  logic                     out_free;
  logic                     load_out;
  logic                     accept;
  logic signed [CW-1:0]     blk_in;
  logic                     blk_ok;
  logic                     head_ok;
  logic                     walk_go;
  logic [PW-1:0]            prod;

  assign out_free = !out_valid || out_ready;
  assign load_out = (state == S_IDLE) && pend && out_free;
  assign in_ready = (state == S_IDLE) && (!pend || out_free);
  assign accept   = in_valid && in_ready;
  assign blk_in   = CW'(block);
  assign blk_ok   = in_pool(blk_r);
  assign head_ok  = !head[LW-1];
  assign walk_go  = in_pool(cur) && (32'(walk_n) < BLOCK_COUNT);
  assign prod     = PW'(res[CW-2:0]) * PW'(block_stride);

  // The free-link RAM is read only at the head; the chain-link RAM at the
  // addressed block, or while walking a chain at the link just read.
  assign fl_raddr = head[IW-1:0];
  assign cl_raddr = (state == S_WALK) ? cl_rdata[IW-1:0] : blk_in[IW-1:0];

  always_comb begin
    fl_we    = 1'b0;
    fl_waddr = head[IW-1:0];
    fl_wdata = head;
    cl_we    = 1'b0;
    cl_waddr = blk_r[IW-1:0];
    cl_wdata = tgt_r;
    case (state)
      S_CLEAR: begin
        fl_we    = 1'b1;
        fl_waddr = clr_cnt;
        fl_wdata = {1'b0, clr_cnt} - LW'(1);
      end
      S_EXEC: begin
        case (op_r)
          OP_ALLOC, OP_ALLOC_LINK: begin
            if (head_ok && (fl_rdata != TAKEN_L)) begin
              fl_we    = 1'b1;
              fl_wdata = TAKEN_L;
              cl_we    = 1'b1;
              cl_waddr = head[IW-1:0];
              cl_wdata = NONE_C;
            end
          end
          OP_FREE: begin
            if (blk_ok) begin
              fl_we    = 1'b1;
              fl_waddr = blk_r[IW-1:0];
            end
          end
          OP_SET_LINK: begin
            cl_we = blk_ok;
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        if (walk_go) begin
          fl_we    = 1'b1;
          fl_waddr = cur[IW-1:0];
        end
      end
      S_LINK: begin
        cl_we    = 1'b1;
        cl_wdata = res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_stride <= STRIDE_RESET;
    end else if (cfg_wr_en) begin
      block_stride <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      head      <= LW'(BLOCK_COUNT - 1);
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IW'(1);
          if (clr_cnt == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          // A waiting result moves to the output register whenever that register frees up.
          if (load_out) begin
            result_block <= FIELD_W'(res);
            status       <= st;
            byte_offset  <= res[CW-1] ? '0 : OFFSET_W'(prod);
            pend         <= 1'b0;
          end
          if (accept) begin
            op_r   <= opcode;
            blk_r  <= blk_in;
            tgt_r  <= CW'(link_target);
            cur    <= blk_in;
            walk_n <= '0;
            state  <= (opcode == OP_FREE_CHAIN) ? S_WALK : S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_r)
            OP_ALLOC, OP_ALLOC_LINK: begin
              if (head_ok && (fl_rdata != TAKEN_L)) begin
                res  <= CW'(head);
                st   <= ST_OK;
                head <= fl_rdata;
                // Appending to an in-range block needs the chain-link write port once more.
                if ((op_r == OP_ALLOC_LINK) && blk_ok) begin
                  state <= S_LINK;
                end else begin
                  pend  <= 1'b1;
                  state <= S_IDLE;
                end
              end else begin
                res   <= NONE_C;
                st    <= head_ok ? ST_CORRUPT : ST_EMPTY;
                pend  <= 1'b1;
                state <= S_IDLE;
              end
            end
            OP_FREE: begin
              res   <= blk_ok ? cl_rdata : NONE_C;
              st    <= ST_OK;
              pend  <= 1'b1;
              state <= S_IDLE;
              if (blk_ok) begin
                head <= LW'(blk_r);
              end
            end
            OP_GET_LINK: begin
              res   <= blk_ok ? cl_rdata : NONE_C;
              st    <= ST_OK;
              pend  <= 1'b1;
              state <= S_IDLE;
            end
            default: begin
              res   <= NONE_C;
              st    <= ST_OK;
              pend  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_WALK: begin
          if (walk_go) begin
            head   <= LW'(cur);
            cur    <= cl_rdata;
            walk_n <= walk_n + (IW+1)'(1);
          end else begin
            res   <= NONE_C;
            st    <= ST_OK;
            pend  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_LINK: begin
          pend  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  lbfl_ram #(
    .DEPTH (BLOCK_COUNT),
    .WIDTH (LW)
  ) u_free_link (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  lbfl_ram #(
    .DEPTH (BLOCK_COUNT),
    .WIDTH (CW)
  ) u_chain_link (
    .clk   (clk),
    .we    (cl_we),
    .waddr (cl_waddr),
    .wdata (cl_wdata),
    .raddr (cl_raddr),
    .rdata (cl_rdata)
  );

  // A new result beat only ever comes from a result that was pending.
  a_out_from_pend: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pend))
    else $error("result beat appeared without a pending result");

  // A pending result exists only while waiting in the idle state.
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_IDLE))
    else $error("pending result outside the idle state");

  // The free head never holds the allocated marker.
  a_head_not_taken: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |-> (head != TAKEN_L))
    else $error("free head holds the allocated marker");

  // An accepted beat always starts a read-modify-write or a chain walk.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((state == S_EXEC) || (state == S_WALK)))
    else $error("accepted beat did not start processing");

  // A chain walk never frees more blocks than the pool holds.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (32'(walk_n) <= BLOCK_COUNT))
    else $error("chain walk exceeded the pool size");

endmodule
